// ===== hdl/tosr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_pkg
// Shared widths, constants and types of the one-slot TCP reorder block.
// ----------------------------------------------------------------------------
package tosr_pkg;

   localparam int TAG_WIDTH_DEF = 16;   // default kept tag bits
   localparam int TAG_PORT_W    = 16;   // tag width on the channels
   localparam int SEQ_W         = 32;
   localparam int LEN_W         = 16;
   localparam int HDR_WORDS_W   = 4;
   localparam int HDR_SHIFT     = 2;    // header words to bytes
   localparam int QUEUE_DEPTH   = 2;

   // One release command from the front to the back: one or two words.
   typedef struct packed {
      logic                  two;
      logic [TAG_PORT_W-1:0] tag0;
      logic [TAG_PORT_W-1:0] tag1;
   } cmd_type;

   // a is older than b under modulo 2^32 sequence arithmetic
   function automatic logic seq_older(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
   endfunction

endpackage

// ===== hdl/tosr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_req_if
// Segment descriptor channel: valid/ready plus the segment fields.
// ----------------------------------------------------------------------------
interface tosr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   syn_flag;
   logic [tosr_pkg::SEQ_W-1:0]             sequence_number;
   logic [tosr_pkg::LEN_W-1:0]             ip_total_length;
   logic [tosr_pkg::HDR_WORDS_W-1:0]       ip_header_words;
   logic [tosr_pkg::HDR_WORDS_W-1:0]       tcp_header_words;
   logic [tosr_pkg::TAG_PORT_W-1:0]        packet_tag;

   modport source (output valid, syn_flag, sequence_number, ip_total_length,
                   ip_header_words, tcp_header_words, packet_tag,
                   input ready);
   modport sink   (input valid, syn_flag, sequence_number, ip_total_length,
                   ip_header_words, tcp_header_words, packet_tag,
                   output ready);
endinterface

// ===== hdl/tosr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_rsp_if
// Release channel: valid/ready plus the released tag and last marker.
// ----------------------------------------------------------------------------
interface tosr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tosr_pkg::TAG_PORT_W-1:0] release_tag;
   logic                            last_release;

   modport source (output valid, release_tag, last_release, input ready);
   modport sink   (input valid, release_tag, last_release, output ready);
endinterface

// ===== hdl/tosr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_front
// Takes segment words, computes payload length, classifies against the
// expected sequence and the held slot, and issues release commands.
// ----------------------------------------------------------------------------
module tosr_front #(
   parameter int TAG_WIDTH = tosr_pkg::TAG_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tosr_req_if.sink          req_chan,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output tosr_pkg::cmd_type cmd
);

   localparam int KEEP_W = (TAG_WIDTH < tosr_pkg::TAG_PORT_W) ?
                           TAG_WIDTH : tosr_pkg::TAG_PORT_W;
   localparam int SEQ_W  = tosr_pkg::SEQ_W;
   localparam int LEN_W  = tosr_pkg::LEN_W;
   localparam int HDR_W  = tosr_pkg::HDR_WORDS_W + tosr_pkg::HDR_SHIFT + 1;

   // stage 1: captured word with its payload length
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_syn_ff;
   logic [SEQ_W-1:0]  s1_seq_ff;
   logic [LEN_W-1:0]  s1_len_ff, s1_len_in;
   logic [KEEP_W-1:0] s1_tag_ff;

   // reorder state
   logic [SEQ_W-1:0]  exp_ff, exp_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [SEQ_W-1:0]  held_seq_ff;
   logic [SEQ_W-1:0]  held_end_ff;
   logic [KEEP_W-1:0] held_tag_ff;

   logic [HDR_W-1:0]  hdr_bytes;
   logic [LEN_W:0]    len_diff;
   logic              accept;
   logic [SEQ_W-1:0]  end_new;
   logic              is_older, is_equal, new_first;
   logic              push_needed, do_hold, s1_go;
   logic [tosr_pkg::TAG_PORT_W-1:0] new_tag, old_tag;

   // payload length, saturating at zero
   always_comb begin
      hdr_bytes = HDR_W'({req_chan.ip_header_words, 2'b00})
                + HDR_W'({req_chan.tcp_header_words, 2'b00});
      len_diff  = {1'b0, req_chan.ip_total_length} - (LEN_W+1)'(hdr_bytes);
      s1_len_in = len_diff[LEN_W] ? '0 : len_diff[LEN_W-1:0];
   end

   assign new_tag = tosr_pkg::TAG_PORT_W'(s1_tag_ff);
   assign old_tag = tosr_pkg::TAG_PORT_W'(held_tag_ff);
   assign end_new = s1_seq_ff + SEQ_W'(s1_len_ff);
   assign is_older  = tosr_pkg::seq_older(s1_seq_ff, exp_ff);
   assign is_equal  = (s1_seq_ff == exp_ff);
   assign new_first = tosr_pkg::seq_older(s1_seq_ff, held_seq_ff);

   always_comb begin
      push_needed   = 1'b1;
      do_hold       = 1'b0;
      exp_in        = exp_ff;
      hold_valid_in = hold_valid_ff;
      cmd.two       = 1'b0;
      cmd.tag0      = new_tag;
      cmd.tag1      = new_tag;
      if (s1_syn_ff) begin
         exp_in        = s1_seq_ff + SEQ_W'(1);
         hold_valid_in = 1'b0;
      end else if (is_older) begin
         // late segment goes straight out, state untouched
      end else if (!hold_valid_ff) begin
         if (is_equal) begin
            exp_in = end_new;
         end else begin
            push_needed   = 1'b0;
            do_hold       = 1'b1;
            hold_valid_in = 1'b1;
         end
      end else begin
         exp_in        = tosr_pkg::seq_older(end_new, held_end_ff) ?
                         held_end_ff : end_new;
         hold_valid_in = 1'b0;
         cmd.two       = 1'b1;
         cmd.tag0      = new_first ? new_tag : old_tag;
         cmd.tag1      = new_first ? old_tag : new_tag;
      end
   end

   assign s1_go          = s1_valid_ff && (!push_needed || cmd_ready);
   assign cmd_valid      = s1_valid_ff && push_needed;
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         exp_ff        <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            exp_ff        <= exp_in;
            hold_valid_ff <= hold_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_syn_ff <= req_chan.syn_flag;
         s1_seq_ff <= req_chan.sequence_number;
         s1_len_ff <= s1_len_in;
         s1_tag_ff <= req_chan.packet_tag[KEEP_W-1:0];
      end
      if (s1_go && do_hold) begin
         held_seq_ff <= s1_seq_ff;
         held_end_ff <= end_new;
         held_tag_ff <= s1_tag_ff;
      end
   end

endmodule

// ===== hdl/tosr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tosr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tosr_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tosr_pkg::cmd_type pop_cmd
);

   localparam int DEPTH = tosr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tosr_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/tosr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosr_back
// Expands release commands into one or two words on the output register.
// ----------------------------------------------------------------------------
module tosr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  tosr_pkg::cmd_type cmd,
   tosr_rsp_if.source        rsp_chan
);

   logic                            out_valid_ff, out_valid_in;
   logic [tosr_pkg::TAG_PORT_W-1:0] out_tag_ff, out_tag_in;
   logic                            out_last_ff, out_last_in;
   logic                            sec_valid_ff, sec_valid_in;
   logic [tosr_pkg::TAG_PORT_W-1:0] sec_tag_ff;
   logic                            out_free, take;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cmd_ready = out_free && !sec_valid_ff;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      sec_valid_in = sec_valid_ff;
      if (out_free) begin
         if (sec_valid_ff) begin
            out_valid_in = 1'b1;
            out_tag_in   = sec_tag_ff;
            out_last_in  = 1'b1;
            sec_valid_in = 1'b0;
         end else if (cmd_valid) begin
            out_valid_in = 1'b1;
            out_tag_in   = cmd.tag0;
            out_last_in  = !cmd.two;
            sec_valid_in = cmd.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
      if (take) begin
         sec_tag_ff <= cmd.tag1;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.release_tag  = out_tag_ff;
   assign rsp_chan.last_release = out_last_ff;

endmodule

// ===== hdl/tcp_one_slot_reorder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_one_slot_reorder
// One-slot TCP segment reorderer: tracks the expected sequence number,
// holds back at most one out-of-order segment and releases packet tags,
// a released pair in sequence order and late segments at once.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          word
//  --------  ---  -----------------  ---------------------------------------
//  req_chan  in   valid/ready        syn, seq, IP len, hdr words, tag
//  rsp_chan  out  valid/ready        release_tag, last_release
//
//  A word is held in the front register, where length is known, and is
//  classified there against the state; state updates as it leaves.
//  A two-entry command queue sits between front and back. The back emits one word
//  per cycle while the output is ready; it stages the second tag of a pair and takes
//  no new command until that tag is out. A tag passes front register, queue, output register.
//  Synchronous active-high reset clears state and valid flags; held slot needs none.
//
module tcp_one_slot_reorder #(
   parameter int TAG_WIDTH = tosr_pkg::TAG_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tosr_req_if.sink    req_chan,
   tosr_rsp_if.source  rsp_chan
);

   logic              fq_valid, fq_ready;
   tosr_pkg::cmd_type fq_cmd;
   logic              qb_valid, qb_ready;
   tosr_pkg::cmd_type qb_cmd;

   // front: length, classification, reorder state
   tosr_front #(
      .TAG_WIDTH(TAG_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   // decoupling queue
   tosr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // back: one or two release words per command
   tosr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp_chan  (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // the second word of a pair is staged and follows the first at once
   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_release)
      |=> (rsp_chan.valid && rsp_chan.last_release))
      else $error("second release word did not follow the first");

   // nothing is presented in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("release word valid right after reset");

   // a full queue must be offering a command while the output is idle
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (!rsp_chan.valid && !fq_ready) |-> qb_valid)
      else $error("command queue full with idle output");
`endif

endmodule
